### design/atl_pkg.sv
// shared types, token codes and character constants of the arithmetic token lexer
// no dependencies
package atl_pkg;

   localparam int LINE_BYTES_DEFAULT  = 4096;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int POS_W               = 13;
   localparam int VALUE_W             = 31;
   localparam int KIND_W              = 4;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   localparam logic [KIND_W-1:0] TK_PLUS    = 4'd0;
   localparam logic [KIND_W-1:0] TK_MINUS   = 4'd1;
   localparam logic [KIND_W-1:0] TK_TIMES   = 4'd2;
   localparam logic [KIND_W-1:0] TK_DIVIDE  = 4'd3;
   localparam logic [KIND_W-1:0] TK_LPAREN  = 4'd4;
   localparam logic [KIND_W-1:0] TK_RPAREN  = 4'd5;
   localparam logic [KIND_W-1:0] TK_LSQUARE = 4'd6;
   localparam logic [KIND_W-1:0] TK_RSQUARE = 4'd7;
   localparam logic [KIND_W-1:0] TK_INTEGER = 4'd8;
   localparam logic [KIND_W-1:0] TK_IDENT   = 4'd9;
   localparam logic [KIND_W-1:0] TK_END     = 4'd10;
   localparam logic [KIND_W-1:0] TK_OTHER   = 4'd11;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LSQUARE = 8'h5B;
   localparam logic [7:0] CH_RSQUARE = 8'h5D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   typedef enum logic [1:0] {
      CLS_DIGIT,
      CLS_WORD,
      CLS_SINGLE
   } char_class_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  token_kind;
      logic [VALUE_W-1:0] int_value;
      logic [POS_W-1:0]   start_pos;
      logic [POS_W-1:0]   end_pos;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic              eol;
      char_class_type    cls;
      logic [3:0]        digit;
      logic [KIND_W-1:0] single_kind;
   } class_word_type;

endpackage

### design/atl_queue.sv
// small first-in first-out queue of register entries
// generic width, used between front and back and at the result side
module atl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");

   a_empty_no_ptr_move: assert property (@(posedge clock) disable iff (reset)
      empty && !do_push |=> rd_ptr_ff == wr_ptr_ff)
      else $error("pointers differ with empty queue");

endmodule

### design/atl_front.sv
// front part: takes input words and classifies each byte
// depends on atl_pkg
module atl_front (
   input  logic                    push,
   output logic                    full,
   input  atl_pkg::req_type        req_data,
   output logic                    mid_push,
   input  logic                    mid_full,
   output atl_pkg::class_word_type mid_word
);
   import atl_pkg::*;

   logic [7:0] c;

   assign c        = req_data.char_code;
   assign full     = mid_full;
   assign mid_push = push;

   always_comb begin
      mid_word.eol   = req_data.kind;
      mid_word.digit = 4'(c - CH_ZERO);
      if (c inside {[CH_ZERO:CH_NINE]}) begin
         mid_word.cls = CLS_DIGIT;
      end else if (c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], CH_UNDER}) begin
         mid_word.cls = CLS_WORD;
      end else begin
         mid_word.cls = CLS_SINGLE;
      end
      case (c)
         CH_PLUS:    mid_word.single_kind = TK_PLUS;
         CH_MINUS:   mid_word.single_kind = TK_MINUS;
         CH_STAR:    mid_word.single_kind = TK_TIMES;
         CH_SLASH:   mid_word.single_kind = TK_DIVIDE;
         CH_LPAREN:  mid_word.single_kind = TK_LPAREN;
         CH_RPAREN:  mid_word.single_kind = TK_RPAREN;
         CH_LSQUARE: mid_word.single_kind = TK_LSQUARE;
         CH_RSQUARE: mid_word.single_kind = TK_RSQUARE;
         default:    mid_word.single_kind = TK_OTHER;
      endcase
   end

endmodule

### design/atl_back.sv
// back part: run tracking, decimal accumulation, positions and token building
// depends on atl_pkg; one token per cycle into the result queue while it is not full
module atl_back #(
   parameter int LINE_BYTES = atl_pkg::LINE_BYTES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    mid_valid,
   input  atl_pkg::class_word_type mid_word,
   output logic                    mid_pop,
   output logic                    out_push,
   input  logic                    out_full,
   output atl_pkg::rsp_type        out_word
);
   import atl_pkg::*;

   localparam int PW = $clog2(LINE_BYTES + 1);
   localparam logic [PW-1:0] POS_LIMIT = PW'(LINE_BYTES);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_INT,
      MODE_IDENT
   } run_mode_type;

   run_mode_type       mode_ff, mode_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [PW-1:0]      run_start_ff, run_start_in;
   logic [PW-1:0]      pos_ff, pos_in;

   logic [PW-1:0]      pos_next;
   logic [VALUE_W+3:0] acc_prod;
   logic [VALUE_W-1:0] acc_sat;
   logic               emit, take, run_grows;
   rsp_type            run_tok;

   assign pos_next = (pos_ff >= POS_LIMIT) ? POS_LIMIT : pos_ff + 1'b1;
   assign acc_prod = (VALUE_W + 4)'({acc_ff, 3'b000}) + (VALUE_W + 4)'({acc_ff, 1'b0}) +
                     (VALUE_W + 4)'(mid_word.digit);
   assign acc_sat  = (acc_prod > (VALUE_W + 4)'(VALUE_MAX)) ? VALUE_MAX : acc_prod[VALUE_W-1:0];

   always_comb begin
      run_tok.token_kind  = (mode_ff == MODE_INT) ? TK_INTEGER : TK_IDENT;
      run_tok.int_value   = (mode_ff == MODE_INT) ? acc_ff : '0;
      run_tok.start_pos   = POS_W'(run_start_ff);
      run_tok.end_pos     = POS_W'(pos_ff);
      run_tok.last_of_run = 1'b0;
   end

   assign run_grows = ((mode_ff == MODE_INT) && (mid_word.cls == CLS_DIGIT)) ||
                      ((mode_ff == MODE_IDENT) && (mid_word.cls != CLS_SINGLE));

   always_comb begin
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      run_start_in = run_start_ff;
      pos_in       = pos_ff;
      emit         = 1'b0;
      take         = 1'b0;
      out_word     = run_tok;
      if (mid_valid) begin
         if (mid_word.eol) begin
            emit = 1'b1;
            if (mode_ff != MODE_IDLE) begin
               // flush the pending run; the end of line word stays and gives the end token once idle
               if (!out_full) begin
                  mode_in = MODE_IDLE;
                  acc_in  = '0;
               end
            end else begin
               out_word.token_kind  = TK_END;
               out_word.int_value   = '0;
               out_word.start_pos   = POS_W'(pos_ff);
               out_word.end_pos     = POS_W'(pos_ff);
               out_word.last_of_run = 1'b1;
               if (!out_full) begin
                  take         = 1'b1;
                  pos_in       = '0;
                  run_start_in = '0;
               end
            end
         end else if (run_grows) begin
            take   = 1'b1;
            pos_in = pos_next;
            if (mode_ff == MODE_INT) begin
               acc_in = acc_sat;
            end
         end else if (mode_ff != MODE_IDLE) begin
            emit                 = 1'b1;
            out_word.last_of_run = (mid_word.cls != CLS_SINGLE);
            if (!out_full) begin
               mode_in = MODE_IDLE;
               acc_in  = '0;
               if (mid_word.cls != CLS_SINGLE) begin
                  // terminating byte opens a new run in the same cycle
                  take         = 1'b1;
                  mode_in      = (mid_word.cls == CLS_DIGIT) ? MODE_INT : MODE_IDENT;
                  acc_in       = (mid_word.cls == CLS_DIGIT) ?
                                 VALUE_W'(mid_word.digit) : '0;
                  run_start_in = pos_ff;
                  pos_in       = pos_next;
               end
            end
         end else if (mid_word.cls == CLS_DIGIT) begin
            take         = 1'b1;
            mode_in      = MODE_INT;
            acc_in       = VALUE_W'(mid_word.digit);
            run_start_in = pos_ff;
            pos_in       = pos_next;
         end else if (mid_word.cls == CLS_WORD) begin
            take         = 1'b1;
            mode_in      = MODE_IDENT;
            acc_in       = '0;
            run_start_in = pos_ff;
            pos_in       = pos_next;
         end else begin
            emit                 = 1'b1;
            out_word.token_kind  = mid_word.single_kind;
            out_word.int_value   = '0;
            out_word.start_pos   = POS_W'(pos_ff);
            out_word.end_pos     = POS_W'(pos_next);
            out_word.last_of_run = 1'b1;
            if (!out_full) begin
               take   = 1'b1;
               pos_in = pos_next;
            end
         end
      end
   end

   assign out_push = emit && !out_full;
   assign mid_pop  = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         acc_ff       <= '0;
         run_start_ff <= '0;
         pos_ff       <= '0;
      end else begin
         mode_ff      <= mode_in;
         acc_ff       <= acc_in;
         run_start_ff <= run_start_in;
         pos_ff       <= pos_in;
      end
   end

   a_acc_only_in_int: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_INT |-> acc_ff == '0)
      else $error("accumulator nonzero outside integer run");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT && run_start_ff <= pos_ff)
      else $error("position out of range");

   a_pop_ends_word: assert property (@(posedge clock) disable iff (reset)
      take && emit |-> out_word.last_of_run)
      else $error("word retired before its last token");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      emit && out_full |=> $stable(pos_ff) && $stable(mode_ff) && $stable(acc_ff))
      else $error("state moved while result side stalled");

endmodule

### design/arithmetic_token_lexer_core.sv
// top level of the arithmetic token lexer
// depends on atl_pkg, atl_front, atl_queue, atl_back
//
// input channel: one word per byte of a text line, or an end-of-line mark
// (kind = 1); a word is taken at a clock edge with push high and full low.
// result channel: tokens in order; the oldest is on rsp_data while empty is
// low and is taken at an edge with pop high.
// the front classifies each byte and writes it into a small queue; the back
// tracks the pending digit or identifier run and builds tokens into the
// result queue, one token per cycle while that queue has room.
// throughput: one input word per cycle while the back does not hold; a word
// that ends a run and also gives a token of its own (or an end of line after
// a run) holds the back until both of its tokens are written, one after the other.
// a taken word is written into the middle queue, and the back then writes
// the first token that it causes into the result queue, and a second token
// after that; a run token waits for the byte after it.
// reset clears both queues, the run state and the byte position.
// when the receiver stalls the result queue fills, then the back holds and
// the middle queue fills, and then full rises.
module arithmetic_token_lexer_core #(
   parameter int LINE_BYTES  = atl_pkg::LINE_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = atl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  atl_pkg::req_type req_data,
   input  logic             pop,
   output logic             empty,
   output atl_pkg::rsp_type rsp_data
);
   import atl_pkg::*;

   localparam int MID_W = $bits(class_word_type);
   localparam int RSP_W = $bits(rsp_type);

   logic           mid_push, mid_full, mid_empty, mid_pop;
   class_word_type mid_in_word, mid_head;
   logic [MID_W-1:0] mid_head_bits;
   logic           out_push, out_full;
   rsp_type        out_word;
   logic [RSP_W-1:0] rsp_bits;

   atl_front u_front (
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .mid_push (mid_push),
      .mid_full (mid_full),
      .mid_word (mid_in_word)
   );

   atl_queue #(
      .WIDTH (MID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (MID_W'(mid_in_word)),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_head_bits),
      .empty   (mid_empty)
   );

   assign mid_head = class_word_type'(mid_head_bits);

   atl_back #(
      .LINE_BYTES (LINE_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (!mid_empty),
      .mid_word  (mid_head),
      .mid_pop   (mid_pop),
      .out_push  (out_push),
      .out_full  (out_full),
      .out_word  (out_word)
   );

   atl_queue #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (RSP_W'(out_word)),
      .full    (out_full),
      .pop     (pop),
      .rd_data (rsp_bits),
      .empty   (empty)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule

### tb/atl_checker.sv
`timescale 1ns / 1ps
// atl_checker: watches both channels of the arithmetic token lexer core, predicts
// the token stream word by word and compares every popped word against it
// depends on atl_pkg
module atl_checker #(
   parameter int LINE_BYTES = atl_pkg::LINE_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  atl_pkg::req_type req_data,
   input  logic             pop,
   input  logic             empty,
   input  atl_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import atl_pkg::*;

   typedef enum logic [1:0] {
      RUN_NONE,
      RUN_NUMBER,
      RUN_NAME
   } run_kind_type;

   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_BYTES);

   run_kind_type       run_kind;
   logic [VALUE_W-1:0] value_acc;
   logic [POS_W-1:0]   run_begin;
   logic [POS_W-1:0]   next_pos;
   rsp_type            tokens_due[$];
   rsp_type            due_word;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
   endfunction

   function automatic logic [POS_W-1:0] pos_step(input logic [POS_W-1:0] p);
      return (p >= POS_LIMIT) ? POS_LIMIT : p + 1'b1;
   endfunction

   function automatic logic [KIND_W-1:0] operator_kind(input logic [7:0] c);
      case (c)
         CH_PLUS:    return TK_PLUS;
         CH_MINUS:   return TK_MINUS;
         CH_STAR:    return TK_TIMES;
         CH_SLASH:   return TK_DIVIDE;
         CH_LPAREN:  return TK_LPAREN;
         CH_RPAREN:  return TK_RPAREN;
         CH_LSQUARE: return TK_LSQUARE;
         CH_RSQUARE: return TK_RSQUARE;
         default:    return TK_OTHER;
      endcase
   endfunction

   function automatic rsp_type make_token(input logic [KIND_W-1:0] kind,
                                          input logic [VALUE_W-1:0] value,
                                          input logic [POS_W-1:0] first,
                                          input logic [POS_W-1:0] past);
      rsp_type t;
      t.token_kind  = kind;
      t.int_value   = value;
      t.start_pos   = first;
      t.end_pos     = past;
      t.last_of_run = 1'b0;
      return t;
   endfunction

   function automatic rsp_type run_token();
      if (run_kind == RUN_NUMBER)
         return make_token(TK_INTEGER, value_acc, run_begin, next_pos);
      return make_token(TK_IDENT, '0, run_begin, next_pos);
   endfunction

   task automatic lex_word(input req_type w);
      rsp_type            made[2];
      int                 n;
      logic [7:0]         c;
      logic [VALUE_W+3:0] grown;
      n = 0;
      c = w.char_code;
      if (w.kind) begin
         if (run_kind != RUN_NONE) begin
            made[n] = run_token();
            n++;
         end
         made[n] = make_token(TK_END, '0, next_pos, next_pos);
         n++;
         run_kind  = RUN_NONE;
         value_acc = '0;
         run_begin = '0;
         next_pos  = '0;
      end else if (run_kind == RUN_NUMBER && is_digit(c)) begin
         grown = (VALUE_W + 4)'(value_acc) * (VALUE_W + 4)'(10) +
                 (VALUE_W + 4)'(c - CH_ZERO);
         value_acc = (grown > VALUE_MAX) ? VALUE_MAX : grown[VALUE_W-1:0];
         next_pos = pos_step(next_pos);
      end else if (run_kind == RUN_NAME && (is_digit(c) || is_letter(c) || c == CH_UNDER)) begin
         next_pos = pos_step(next_pos);
      end else begin
         if (run_kind != RUN_NONE) begin
            made[n] = run_token();
            n++;
         end
         run_kind  = RUN_NONE;
         value_acc = '0;
         if (is_digit(c)) begin
            run_kind  = RUN_NUMBER;
            value_acc = VALUE_W'(c - CH_ZERO);
            run_begin = next_pos;
         end else if (is_letter(c) || c == CH_UNDER) begin
            run_kind  = RUN_NAME;
            run_begin = next_pos;
         end else begin
            made[n] = make_token(operator_kind(c), '0, next_pos, pos_step(next_pos));
            n++;
         end
         next_pos = pos_step(next_pos);
      end
      for (int i = 0; i < n; i++) begin
         if (i == n - 1) begin
            made[i].last_of_run = 1'b1;
         end
         tokens_due.push_back(made[i]);
      end
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         run_kind  = RUN_NONE;
         value_acc = '0;
         run_begin = '0;
         next_pos  = '0;
         tokens_due.delete();
      end else begin
         if (push && !full) begin
            lex_word(req_data);
         end
         if (pop && !empty) begin
            if (tokens_due.size() == 0) begin
               $display("%0t: token word with none expected, expected nothing, actual %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               due_word = tokens_due.pop_front();
               check_field("token_kind", due_word.token_kind, rsp_data.token_kind);
               check_field("int_value", due_word.int_value, rsp_data.int_value);
               check_field("start_pos", due_word.start_pos, rsp_data.start_pos);
               check_field("end_pos", due_word.end_pos, rsp_data.end_pos);
               check_field("last_of_run", due_word.last_of_run, rsp_data.last_of_run);
            end
         end
      end
      pending = tokens_due.size();
   end

endmodule

### tb/tb_arithmetic_token_lexer_core.sv
`timescale 1ns / 1ps
// tb_arithmetic_token_lexer_core: feeds text lines into the lexer core in random
// bursts, pops tokens under random stalls and gives the verdict
// depends on atl_pkg, arithmetic_token_lexer_core and atl_checker
module tb_arithmetic_token_lexer_core;
   import atl_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int ITEM_COUNT  = 1800;

   localparam logic [7:0] OPERATORS [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                            CH_LPAREN, CH_RPAREN, CH_LSQUARE, CH_RSQUARE};

   typedef enum int {
      POP_ALWAYS,
      POP_COIN,
      POP_RARE
   } pop_style_type;

   logic          clock    = 1'b0;
   logic          reset    = 1'b1;
   logic          push     = 1'b0;
   logic          full;
   req_type       req_data = '0;
   logic          pop      = 1'b0;
   logic          empty;
   rsp_type       rsp_data;
   int            fail_count;
   int            pending;
   int            idle_cycles    = 0;
   int            words_sent     = 0;
   int            word_target    = ITEM_COUNT;
   int            burst_left     = 0;
   int            pop_phase_left = 0;
   pop_style_type pop_style      = POP_ALWAYS;

   always #5 clock = ~clock;

   arithmetic_token_lexer_core dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

   atl_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .pop        (pop),
      .empty      (empty),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop_phase_left == 0) begin
            pop_style      = pop_style_type'($urandom_range(0, 2));
            pop_phase_left = $urandom_range(16, 160);
         end
         pop_phase_left--;
         case (pop_style)
            POP_ALWAYS: begin
               pop <= 1'b1;
            end
            POP_COIN: begin
               pop <= 1'($urandom_range(0, 1));
            end
            default: begin
               pop <= ($urandom_range(0, 11) == 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("arithmetic_token_lexer_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(input logic eol, input logic [7:0] code);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      push          <= 1'b1;
      req_data.kind      <= eol;
      req_data.char_code <= code;
      @(posedge clock);
      while (full) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_word(1'b0, s[i]);
   endtask

   function automatic logic [7:0] word_char(input bit lead);
      int r;
      r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
      if (r < 26) return 8'(CH_LOWER_A + r);
      if (r < 52) return 8'(CH_UPPER_A + r - 26);
      if (r == 52) return CH_UNDER;
      return 8'(CH_ZERO + r - 53);
   endfunction

   task automatic send_token();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         send_word(1'b0, OPERATORS[3'($urandom_range(0, 7))]);
      end else if (pick < 50) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
         repeat (len) begin
            send_word(1'b0, 8'(CH_ZERO + (($urandom_range(0, 2) == 0) ? 9 : $urandom_range(0, 9))));
         end
      end else if (pick < 75) begin
         send_word(1'b0, word_char(1'b1));
         repeat ($urandom_range(0, 7)) send_word(1'b0, word_char(1'b0));
      end else if (pick < 88) begin
         send_word(1'b0, 8'h20);
      end else begin
         send_word(1'b0, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      send_text("+-*/()[]_zA9");
      send_word(1'b0, 8'h00);
      send_text("4294967296");
      send_word(1'b0, 8'hFF);
      send_word(1'b1, 8'hFF);
      while (words_sent < word_target) begin
         repeat ($urandom_range(0, 12)) send_token();
         send_word(1'b1, 8'($urandom_range(0, 255)));
      end
      push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("arithmetic_token_lexer_core test passed");
      end else begin
         $display("arithmetic_token_lexer_core test failed");
      end
      $finish;
   end

endmodule
